@@ rtl/core/swpsf_pkg.sv @@
// shared types, constants and helpers of the sorted word prefix/suffix filter
package swpsf_pkg;

    localparam int CHAR_W      = 8;
    localparam int CNT_W       = 4;
    localparam int TEXT_W      = 64;
    localparam int LEN_W       = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] CFG_FOLD_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_TEXT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX_TEXT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX_COUNT = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

    typedef enum logic [1:0] {
        CMP_EQUAL = 2'd0,
        CMP_BELOW = 2'd1,
        CMP_ABOVE = 2'd2
    } t_cmp;

    typedef struct packed {
        logic              fold_mode;
        logic [TEXT_W-1:0] prefix_text;
        logic [CNT_W-1:0]  prefix_count;
        logic [TEXT_W-1:0] suffix_text;
        logic [CNT_W-1:0]  suffix_count;
    } t_cfg;

    // packed so that matched sits in bit 0
    typedef struct packed {
        logic [LEN_W-1:0] char_count;
        logic             past_range;
        logic             matched;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_push;

    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic fold);
        logic [CHAR_W-1:0] r;
        r = c;
        if (fold && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
            r = c - CHAR_UPPER_A + CHAR_LOWER_A;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/swpsf_word_track.sv @@
// per-word state: prefix compare, recent characters, length, stop latch and result
module swpsf_word_track #(
    parameter int MAX_AFFIX = 8,
    parameter int MAX_WORD  = 80
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swpsf_pkg::t_cfg   i_cfg,
    input  logic              i_step,
    input  logic [7:0]        i_char,
    input  logic              i_end,
    output swpsf_pkg::t_push  o_push
);
    import swpsf_pkg::*;

    localparam int POS_W = $clog2(MAX_WORD);
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int REC_W = CHAR_W * MAX_AFFIX;

    logic [POS_W-1:0] r_pos, n_pos;
    t_cmp             r_cmp, n_cmp;
    logic [REC_W-1:0] r_recent, n_recent;
    logic             r_stopped, n_stopped;

    logic [CNT_W-1:0]  pcount, scount;
    logic [CMP_W-1:0]  pos_ext;
    logic [CHAR_W-1:0] fc, pc;
    logic              suffix_ok;
    t_push             push;

    always_comb begin
        pcount = (i_cfg.prefix_count > CNT_W'(MAX_AFFIX)) ? CNT_W'(MAX_AFFIX)
                                                          : i_cfg.prefix_count;
        scount = (i_cfg.suffix_count > CNT_W'(MAX_AFFIX)) ? CNT_W'(MAX_AFFIX)
                                                          : i_cfg.suffix_count;
        pos_ext = CMP_W'(r_pos);
        fc = fold_char(i_char, i_cfg.fold_mode);
        pc = fold_char(i_cfg.prefix_text[CHAR_W*pos_ext[2:0] +: CHAR_W], i_cfg.fold_mode);

        // each suffix lane checks independently, lanes past the count pass
        suffix_ok = (pos_ext >= CMP_W'(scount));
        for (int i = 0; i < MAX_AFFIX; i++) begin
            if ((CNT_W'(i) < scount) &&
                (fold_char(i_cfg.suffix_text[CHAR_W*i +: CHAR_W], i_cfg.fold_mode)
                 != r_recent[CHAR_W*i +: CHAR_W])) begin
                suffix_ok = 1'b0;
            end
        end

        n_pos     = r_pos;
        n_cmp     = r_cmp;
        n_recent  = r_recent;
        n_stopped = r_stopped;
        push      = '0;
        push.data.char_count = LEN_W'(r_pos);

        if (i_step && !i_end) begin
            if ((r_cmp == CMP_EQUAL) && (pos_ext < CMP_W'(pcount))) begin
                if (fc < pc) begin
                    n_cmp = CMP_BELOW;
                end else if (fc > pc) begin
                    n_cmp = CMP_ABOVE;
                end
            end
            n_recent         = r_recent << CHAR_W;
            n_recent[CHAR_W-1:0] = fc;
            if (pos_ext < CMP_W'(MAX_WORD - 1)) begin
                n_pos = r_pos + POS_W'(1);
            end
        end else if (i_step && i_end) begin
            push.valid = 1'b1;
            if (r_stopped) begin
                push.data.past_range = 1'b1;
            end else if (r_cmp == CMP_ABOVE) begin
                push.data.past_range = 1'b1;
                n_stopped            = 1'b1;
            end else if ((r_cmp == CMP_EQUAL) && (pos_ext >= CMP_W'(pcount))) begin
                push.data.matched = (scount == '0) || suffix_ok;
            end
            n_pos    = '0;
            n_cmp    = CMP_EQUAL;
            n_recent = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_cmp     <= CMP_EQUAL;
            r_recent  <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_cmp     <= n_cmp;
            r_recent  <= n_recent;
            r_stopped <= n_stopped;
        end
    end

    assign o_push = push;

endmodule

@@ rtl/core/swpsf_out_buf.sv @@
// two-entry result buffer: output register plus skid entry
module swpsf_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swpsf_pkg::t_push    i_push,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_ready,
    output swpsf_pkg::t_result  o_data
);
    import swpsf_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_result    r_out, n_out;
    t_result    r_skid, n_skid;
    logic       pop;

    always_comb begin
        pop    = (r_cnt != 2'd0) && i_ready;
        n_cnt  = r_cnt;
        n_out  = r_out;
        n_skid = r_skid;
        case (r_cnt)
            2'd0: begin
                if (i_push.valid) begin
                    n_out = i_push.data;
                    n_cnt = 2'd1;
                end
            end
            2'd1: begin
                if (pop && i_push.valid) begin
                    n_out = i_push.data;
                end else if (pop) begin
                    n_cnt = 2'd0;
                end else if (i_push.valid) begin
                    n_skid = i_push.data;
                    n_cnt  = 2'd2;
                end
            end
            default: begin
                // full: no push can arrive here
                if (pop) begin
                    n_out = r_skid;
                    n_cnt = 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_out;

endmodule

@@ rtl/core/sorted_word_prefix_suffix_filter.sv @@
// top level of the sorted word prefix/suffix filter
// A sorted word list streams in one character per transfer; a transfer with tlast high is the
// newline that closes a word and carries no character. For each closed word the block returns
// one result transfer telling whether the word starts with the prefix and ends with the suffix
// (up to MAX_AFFIX characters each, optionally case folded), whether it sorts past the prefix
// range, and its length saturated at MAX_WORD-1. Once a word sorts past the range the scan is
// stopped until reset and every later word reports past_range. Throughput is one transfer per
// cycle: a character is taken into the input register, and the word logic between that register
// and the two-entry result buffer handles it in the next cycle. A word end goes from the input
// register through the word logic into the result buffer, which drives o_m_tdata. The input
// stalls only while a word end is waiting and both result buffer entries are held by the
// downstream side. Configuration writes act on the next cycle and are meant for idle times only.
module sorted_word_prefix_suffix_filter #(
    parameter int MAX_AFFIX = 8,
    parameter int MAX_WORD  = 80
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input stream
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [swpsf_pkg::IN_TDATA_W-1:0]      i_s_tdata,   // [7:0] char_code
    input  logic                                  i_s_tlast,   // word_end
    // result stream
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // [0] matched, [1] past_range, [8:2] char count, [15:9] zero
    output logic [swpsf_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [swpsf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [swpsf_pkg::TEXT_W-1:0]          i_cfg_wdata
);
    import swpsf_pkg::*;

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FOLD_MODE:    r_cfg.fold_mode    <= i_cfg_wdata[0];
                CFG_PREFIX_TEXT:  r_cfg.prefix_text  <= i_cfg_wdata;
                CFG_PREFIX_COUNT: r_cfg.prefix_count <= i_cfg_wdata[CNT_W-1:0];
                CFG_SUFFIX_TEXT:  r_cfg.suffix_text  <= i_cfg_wdata;
                CFG_SUFFIX_COUNT: r_cfg.suffix_count <= i_cfg_wdata[CNT_W-1:0];
                default: ; // unused indexes are ignored
            endcase
        end
    end

    // input register
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_end;
    logic              buf_full;
    logic              step;
    logic              in_xfer;

    // a character never needs buffer room, a word end needs a free entry
    assign step       = r_in_valid && (!r_in_end || !buf_full);
    assign o_s_tready = !r_in_valid || step;
    assign in_xfer    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_char <= i_s_tdata[CHAR_W-1:0];
            r_in_end  <= i_s_tlast;
        end
    end

    // word logic
    t_push push;

    swpsf_word_track #(
        .MAX_AFFIX (MAX_AFFIX),
        .MAX_WORD  (MAX_WORD)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (step),
        .i_char  (r_in_char),
        .i_end   (r_in_end),
        .o_push  (push)
    );

    // result buffer
    t_result out_data;

    swpsf_out_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (buf_full),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (out_data)
    );

    assign o_m_tdata = OUT_TDATA_W'(out_data);

endmodule

@@ rtl/core/swpsf_checker.sv @@
// port-level checks of the sorted word prefix/suffix filter, bound to the top level
module swpsf_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    input  logic [swpsf_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);
    import swpsf_pkg::*;

    // set once a result transfer has reported past_range
    logic r_seen_past;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_past <= 1'b0;
        end else if (o_m_tvalid && i_m_tready && o_m_tdata[1]) begin
            r_seen_past <= 1'b1;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // a word never both matches and lies past the range
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]))
        else $error("matched together with past_range");

    // stop state is sticky until reset
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_seen_past |-> o_m_tdata[1] && !o_m_tdata[0])
        else $error("word after stop not reported past range");

    // unused tdata bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[OUT_TDATA_W-1:LEN_W+2] == '0))
        else $error("nonzero padding in result");

endmodule

bind sorted_word_prefix_suffix_filter swpsf_checker u_swpsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata)
);
